>>> hw/rtl/auto_range_pressure_percent_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the auto-ranging pressure percent block.
// Each macro wraps one concurrent assertion clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef AUTO_RANGE_PRESSURE_PERCENT_ASSERT_SVH
`define AUTO_RANGE_PRESSURE_PERCENT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ARPP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ARPP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/arpp_pkg.sv
// ----------------------------------------------------------------------------
// arpp_pkg
// Shared constants and types of the auto-ranging pressure percent block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arpp_pkg;

  // Width of the percent result and the number of quotient bits.
  localparam int unsigned PCT_BITS = 7;

  // Full scale of the percent result.
  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

  // The divider retires one quotient bit per step.
  localparam int unsigned DIV_STEPS = PCT_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/auto_range_pressure_percent.sv
// ----------------------------------------------------------------------------
// auto_range_pressure_percent
// Auto-ranging pressure sensor front end: tracks the minimum and maximum
// samples and reports each sample as a percent of the tracked span.
// ----------------------------------------------------------------------------
// Each input beat carries one raw ADC sample. The block folds the sample into
// the running maximum and minimum (reset to 0 and to all ones), forms the span
// as their difference clamped to at least 1, and returns one output beat with
// (max - sample) * 100 / span, truncated and capped at 100, next to the
// updated maximum and minimum. A sample at the minimum reads 100 and one at
// the maximum reads 0. Between its input beat and the next input beat a
// sample is captured, folded into the range, turned into the scaled
// difference and the span, run through the bit-serial divider (one
// quotient bit per cycle), and handed as a result to the output register.
// The input is not ready while a sample is in work. The output register
// holds a finished beat while the next sample is taken, so a slow consumer
// only stalls the block when a second result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module auto_range_pressure_percent #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // Input stream. tdata: sample [SAMPLE_BITS-1:0], zero padding above.
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata_i,
  // Output stream. tdata: percent [6:0], range_high, range_low, zero padding.
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  output logic [((arpp_pkg::PCT_BITS+2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o
);
  import arpp_pkg::*;

  localparam int unsigned NumW = SAMPLE_BITS + PCT_BITS;
  localparam int unsigned HiLo = PCT_BITS;
  localparam int unsigned LoLo = PCT_BITS + SAMPLE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RANGE = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]             st_q, st_d;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [SAMPLE_BITS-1:0] floor_q, floor_d;
  logic [SAMPLE_BITS-1:0] span_q, span_d;
  logic                   oor_q;
  logic [PCT_BITS-1:0]    pct_q;
  logic                   out_vld_q;
  logic [PCT_BITS-1:0]    out_pct_q;
  logic [SAMPLE_BITS-1:0] out_high_q;
  logic [SAMPLE_BITS-1:0] out_low_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   div_start;
  logic [NumW-1:0]        num;
  logic [PCT_BITS-1:0]    quo;
  logic [PCT_BITS-1:0]    pct_sat;
  div_stat_t              div_stat;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Range update, done in the cycle after capture.
  assign peak_d  = (samp_q > peak_q)  ? samp_q : peak_q;
  assign floor_d = (samp_q < floor_q) ? samp_q : floor_q;

  // Span from the updated range, never below one so the divisor is nonzero.
  assign span_d = (peak_q > floor_q) ? (peak_q - floor_q) : SAMPLE_BITS'(1);

  // Distance below the maximum scaled to percent; one small constant multiply.
  assign num = NumW'(peak_q - samp_q) * NumW'(PCT_FULL);

  // The divider starts as soon as the scaled distance and the span are formed.
  assign div_start = (st_q == S_LOAD);

  arpp_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  (span_d),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  // Cap at full scale; a sample outside the tracked range reads zero. Neither
  // case can arise once the range has taken the sample in.
  assign pct_sat = oor_q ? '0 : ((quo > PCT_FULL) ? PCT_FULL : quo);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          st_d = S_RANGE;
        end
      end
      S_RANGE: begin
        st_d = S_LOAD;
      end
      S_LOAD: begin
        st_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      peak_q    <= '0;
      floor_q   <= '1;
      span_q    <= SAMPLE_BITS'(1);
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_RANGE) begin
        peak_q  <= peak_d;
        floor_q <= floor_d;
      end
      if (st_q == S_LOAD) begin
        span_q <= span_d;
      end
      if ((st_q == S_OUT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
    end
    if (st_q == S_LOAD) begin
      oor_q <= (samp_q > peak_q) || (samp_q < floor_q);
    end
    if ((st_q == S_DIV) && div_stat.done) begin
      pct_q <= pct_sat;
    end
    if ((st_q == S_OUT) && out_free) begin
      out_pct_q  <= pct_q;
      out_high_q <= peak_q;
      out_low_q  <= floor_q;
    end
  end

  assign s_axis_tready_o = (st_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;

  always_comb begin
    m_axis_tdata_o                        = '0;
    m_axis_tdata_o[PCT_BITS-1:0]          = out_pct_q;
    m_axis_tdata_o[HiLo+SAMPLE_BITS-1:HiLo] = out_high_q;
    m_axis_tdata_o[LoLo+SAMPLE_BITS-1:LoLo] = out_low_q;
  end

  // The span register, formed from the tracked range, is never zero while idle.
  `include "auto_range_pressure_percent_assert.svh"

  `ARPP_ASSERT_IMP(a_range_order, clk_i, rst_ni, m_axis_tvalid_o,
                   out_low_q <= out_high_q, "output minimum above output maximum")
  `ARPP_ASSERT_IMP(a_pct_full, clk_i, rst_ni, m_axis_tvalid_o,
                   out_pct_q <= PCT_FULL, "percent above full scale")
  `ARPP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc,
                   !s_axis_tready_o, "input ready right after an accepted beat")
  `ARPP_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, div_stat.done,
                   st_q == S_DIV, "divider finished outside the divide state")
  `ARPP_ASSERT_IMP(a_span_nonzero, clk_i, rst_ni, st_q == S_IDLE,
                   span_q != '0, "tracked span is zero")

endmodule

`default_nettype wire

>>> hw/rtl/arpp_div.sv
// ----------------------------------------------------------------------------
// arpp_div
// Restoring divider that retires one quotient bit per cycle. The quotient is
// known to stay below 2**PCT_BITS, so only that many steps are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arpp_div #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [SAMPLE_BITS+arpp_pkg::PCT_BITS-1:0] dividend_i,
  input  logic [SAMPLE_BITS-1:0]                 divisor_i,
  output arpp_pkg::div_stat_t                    stat_o,
  output logic [arpp_pkg::PCT_BITS-1:0]          quotient_o
);
  import arpp_pkg::*;

  localparam int unsigned NumW = SAMPLE_BITS + PCT_BITS;

  logic                    busy_q, busy_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [NumW-1:0]         rem_q, rem_d;
  logic [NumW-1:0]         dsh_q, dsh_d;
  logic [PCT_BITS-2:0]     quo_q, quo_d;
  logic                    ge;
  logic                    last;

  // One compare and subtract against the divisor shifted into place.
  assign ge   = (rem_q >= dsh_q);
  assign last = busy_q && (cnt_q == DIV_LAST);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      dsh_d  = {1'b0, divisor_i, {(PCT_BITS-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_q - dsh_q) : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[PCT_BITS-3:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = last;
  assign quotient_o  = {quo_q, ge};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - auto_range_pressure_percent bench
// Streams ADC samples into the block, folds each one into a local running
// minimum, maximum and span, and checks every result beat in order. The fields
// checked are the percent and both range bounds. The traffic cycles through
// phases with no idling, with sender gaps, with receiver stalls, and with both.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((arpp_pkg::PCT_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  // Stop criteria. The slowest phases add sender gaps and receiver stalls on
  // top of the block's own work on each sample, so the cycle limit leaves a
  // wide margin.
  localparam int unsigned RANDOM_SAMPLES = 1500;
  localparam int unsigned PHASE_BEATS = 100;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 32;

  // One result beat, split into its fields.
  typedef struct packed {
    logic [arpp_pkg::PCT_BITS-1:0] percent;
    logic [SAMPLE_BITS-1:0]        range_high;
    logic [SAMPLE_BITS-1:0]        range_low;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  auto_range_pressure_percent #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    // tdata: sample [11:0], zero padding [15:12].
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    // tdata: percent [6:0], range_high [18:7], range_low [30:19], padding [31].
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  logic [SAMPLE_BITS-1:0] pending_samples[$];
  reading_t               expected_readings[$];

  // Local copy of the tracked range, advanced once per accepted sample.
  logic [SAMPLE_BITS-1:0] track_peak = '0;
  logic [SAMPLE_BITS-1:0] track_floor = SAMPLE_MAX;
  logic [SAMPLE_BITS-1:0] track_span = SAMPLE_BITS'(1);

  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned full_scale_hits = 0;
  int unsigned zero_hits = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // The traffic phase advances every PHASE_BEATS accepted samples, so gaps
  // land on every stage of the block's work many times over the run.
  logic [1:0]  traffic_phase;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  assign traffic_phase = 2'((samples_sent / PHASE_BEATS) % 4);
  assign send_idle_pct = (traffic_phase == 2'd1) ? 58 : (traffic_phase == 2'd3) ? 38 : 0;
  assign recv_stall_pct = (traffic_phase == 2'd2) ? 58 : (traffic_phase == 2'd3) ? 38 : 0;

  // Folds one sample into the tracked range and returns the reading it
  // should produce. The range is widened first, so the sample always lies
  // inside it. The out-of-range and saturation branches are kept to mirror
  // the intended behavior even though they never fire.
  function automatic reading_t fold_sample(logic [SAMPLE_BITS-1:0] sample);
    reading_t    reading;
    int unsigned quotient;
    if (sample > track_peak) track_peak = sample;
    if (sample < track_floor) track_floor = sample;
    if (track_peak > track_floor) track_span = track_peak - track_floor;
    else track_span = SAMPLE_BITS'(1);
    if (sample > track_peak || sample < track_floor) begin
      quotient = 0;
    end else begin
      quotient = ((int'(track_peak) - int'(sample)) * int'(arpp_pkg::PCT_FULL))
                 / int'(track_span);
      if (quotient > int'(arpp_pkg::PCT_FULL)) quotient = int'(arpp_pkg::PCT_FULL);
    end
    reading.percent = arpp_pkg::PCT_BITS'(quotient);
    reading.range_high = track_peak;
    reading.range_low = track_floor;
    return reading;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  // Driver: presents the next pending sample, or idles at random, whenever the
  // current beat was taken or none is up. Each accepted beat is predicted right away.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readings.push_back(fold_sample(s_axis_tdata[SAMPLE_BITS-1:0]));
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= S_TDATA_W'(pending_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output at random and checks each taken beat against
  // the oldest reading still waiting.
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.percent = m_axis_tdata[arpp_pkg::PCT_BITS-1:0];
        got.range_high = m_axis_tdata[arpp_pkg::PCT_BITS +: SAMPLE_BITS];
        got.range_low = m_axis_tdata[arpp_pkg::PCT_BITS + SAMPLE_BITS +: SAMPLE_BITS];
        if (expected_readings.size() == 0) begin
          $error("result beat with no sample waiting: tdata 0x%0h", m_axis_tdata);
          error_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("percent", want.percent, got.percent);
          check_field("range_high", want.range_high, got.range_high);
          check_field("range_low", want.range_low, got.range_low);
          results_checked++;
          if (want.percent == arpp_pkg::PCT_FULL) full_scale_hits++;
          if (want.percent == 0) zero_hits++;
        end
      end
    end
  end

  // Watchdog. It covers a hung handshake and results that never arrive.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding",
               cycle_count, expected_readings.size());
      $display("auto_range_pressure_percent: mismatch");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_BITS-1:0] directed[];
    logic [SAMPLE_BITS-1:0] gen_low;
    logic [SAMPLE_BITS-1:0] gen_high;
    logic [SAMPLE_BITS-1:0] sample;
    int unsigned            pick;

    directed = '{
      // Single sample, then a repeat: equal bounds, span clamped to one.
      12'd2048, 12'd2048,
      // One-count span: the top reads 0 and the bottom reads 100.
      12'd2049, 12'd2048,
      // Two-count span gives a midpoint of 50, then it is widened at both ends.
      12'd2050, 12'd2049, 12'd2047, 12'd2050, 12'd2100, 12'd2047,
      // Full-scale extremes, which toggle every sample bit both ways.
      12'd4095, 12'd0, 12'd4095, 12'd0,
      // Samples just inside the full range and near the thirds.
      12'd1, 12'd4094, 12'd2047, 12'd2048, 12'd1365, 12'd2730, 12'd3, 12'd4092
    };

    gen_low = SAMPLE_MAX;
    gen_high = '0;
    foreach (directed[i]) begin
      pending_samples.push_back(directed[i]);
      if (directed[i] < gen_low) gen_low = directed[i];
      if (directed[i] > gen_high) gen_high = directed[i];
    end

    // The random part mixes uniform samples with samples at the tracked
    // bounds and a few counts inside them, where truncation and the edge
    // readings of 0 and 100 are exercised.
    repeat (RANDOM_SAMPLES) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        sample = SAMPLE_BITS'($urandom_range(int'(SAMPLE_MAX), 0));
      end else if (pick < 70) begin
        sample = gen_low + SAMPLE_BITS'($urandom_range(3));
      end else if (pick < 90) begin
        sample = gen_high - SAMPLE_BITS'($urandom_range(3));
      end else begin
        sample = ($urandom_range(1) == 1) ? gen_high : gen_low;
      end
      pending_samples.push_back(sample);
      if (sample < gen_low) gen_low = sample;
      if (sample > gen_high) gen_high = sample;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_samples.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_readings.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_readings.size() > 0) begin
      $error("%0d readings never arrived", expected_readings.size());
      error_count++;
    end

    $display("Sent %0d samples and checked %0d readings in %0d cycles.",
             samples_sent, results_checked, cycle_count);
    $display("Readings at full scale: %0d, readings at zero: %0d, errors: %0d.",
             full_scale_hits, zero_hits, error_count);
    if (error_count == 0) begin
      $display("auto_range_pressure_percent: match");
    end else begin
      $display("auto_range_pressure_percent: mismatch");
    end
    $finish;
  end

endmodule
